// ----- src/bakery_ticket_arbiter_core_defines.svh -----
// Assertion macros shared by the bakery ticket arbiter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BAKERY_TICKET_ARBITER_CORE_DEFINES_SVH
`define BAKERY_TICKET_ARBITER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BTA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BTA_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define BTA_ASSERT(label, clk, rst_n, prop, msg)
`define BTA_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// ----- src/bta_pkg.sv -----
// Shared types and constants for the bakery ticket arbiter.
// No dependencies; used by every module of the block except bta_ram.
package bta_pkg;

	localparam int MAX_REQUESTERS_DEF = 16;
	localparam int TICKET_BITS_DEF    = 16;

	localparam int ID_W     = 4;
	localparam int ID_SPACE = 16;
	localparam int ACT_W    = 5;
	localparam int ISSUE_W  = 16;

	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ID   = 2'd1;
	localparam logic [1:0] ST_DUP      = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic            func;
		logic [ID_W-1:0] requester_id;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ISSUE_W-1:0] issued_ticket;
		logic               holder_valid;
		logic [ID_W-1:0]    holder_id;
	} rsp_item_t;

	typedef struct packed {
		logic latch;
		logic check;
		logic walk;
		logic load_out;
	} bta_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic none_active;
	} bta_stat_t;

endpackage

// ----- src/bta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bta_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/bta_dp.sv -----
// Datapath: config register, ticket RAM with held flags, ticket walk and result register.
// Depends on bta_pkg, bta_ram and the assertion macro header.
`include "bakery_ticket_arbiter_core_defines.svh"

module bta_dp import bta_pkg::*; #(
	parameter int MAX_REQ = MAX_REQUESTERS_DEF,
	parameter int TB      = TICKET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [ACT_W-1:0] cfg_data,
	input  req_item_t        req_item,
	input  bta_cmd_t         cmd,
	output bta_stat_t        stat,
	output rsp_item_t        rsp_item
);

	localparam int AW  = $clog2(MAX_REQ);
	localparam int LIM = (MAX_REQ < ID_SPACE) ? MAX_REQ : ID_SPACE;
	localparam int CW  = AW + ACT_W;
	localparam logic [TB-1:0] TICKET_TOP = {TB{1'b1}};

	logic [ACT_W-1:0]   active_q;
	logic [ACT_W-1:0]   n_eff;
	logic               func_q;
	logic [ID_W-1:0]    id_q;
	logic [1:0]         st_q;
	logic [MAX_REQ-1:0] held_q;
	logic [AW-1:0]      cnt_q;
	logic               rd_v_s1;
	logic               ent_v_s1;
	logic [AW-1:0]      idx_s1;
	logic [TB-1:0]      max_q;
	logic [TB-1:0]      min_t_q;
	logic [AW-1:0]      min_id_q;
	logic               found_q;
	logic [TB-1:0]      ram_rdata;
	logic [AW-1:0]      id_slot;
	logic               bad;
	logic               issue;
	logic               ram_we;
	logic [TB-1:0]      new_ticket;
	rsp_item_t          rsp_q;

	assign n_eff   = (active_q > ACT_W'(LIM)) ? ACT_W'(LIM) : active_q;
	assign id_slot = AW'(id_q);
	assign bad     = ACT_W'(id_q) >= n_eff;

	assign stat.walk_last   = CW'(cnt_q) == (CW'(n_eff) - CW'(1));
	assign stat.none_active = n_eff == '0;

	// Overflow is only known once the walk has found the largest ticket.
	assign issue      = (st_q == ST_OK) && (func_q == FUNC_REQUEST) && (max_q != TICKET_TOP);
	assign ram_we     = cmd.load_out && issue;
	assign new_ticket = max_q + TB'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= req_item.func;
			id_q   <= req_item.requester_id;
		end
		if (cmd.check) begin
			if (bad) begin
				st_q <= ST_BAD_ID;
			end else if (func_q == FUNC_REQUEST && held_q[id_slot]) begin
				st_q <= ST_DUP;
			end else begin
				st_q <= ST_OK;
			end
		end
	end

	// A held flag stands for a nonzero ticket; issued tickets are never zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			if (cmd.check && func_q == FUNC_RELEASE && !bad) begin
				held_q[id_slot] <= 1'b0;
			end
			if (ram_we) begin
				held_q[id_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.walk;
			if (cmd.check) begin
				cnt_q <= '0;
			end else if (cmd.walk) begin
				cnt_q <= AW'(cnt_q + AW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_v_s1 <= held_q[cnt_q];
		idx_s1   <= cnt_q;
	end

	// Ascending walk with a strict compare keeps ties on the lower id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.check) begin
			found_q <= 1'b0;
		end else if (rd_v_s1 && ent_v_s1) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			max_q <= '0;
		end else if (rd_v_s1 && ent_v_s1) begin
			if (ram_rdata > max_q) begin
				max_q <= ram_rdata;
			end
			if (!found_q || ram_rdata < min_t_q) begin
				min_t_q  <= ram_rdata;
				min_id_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (issue) begin
				rsp_q.status        <= ST_OK;
				rsp_q.issued_ticket <= ISSUE_W'(new_ticket);
				rsp_q.holder_valid  <= 1'b1;
				rsp_q.holder_id     <= found_q ? ID_W'(min_id_q) : id_q;
			end else begin
				rsp_q.status <= (st_q == ST_OK && func_q == FUNC_REQUEST) ? ST_OVERFLOW : st_q;
				rsp_q.issued_ticket <= '0;
				rsp_q.holder_valid  <= found_q;
				rsp_q.holder_id     <= found_q ? ID_W'(min_id_q) : '0;
			end
		end
	end

	assign rsp_item = rsp_q;

	bta_ram #(
		.WIDTH (TB),
		.DEPTH (MAX_REQ)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (id_slot),
		.wdata (new_ticket),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	`BTA_ASSERT_NEVER(a_issue_to_free_slot, clk, arst_n, ram_we && held_q[id_slot], "ticket issued to a requester already holding one")
	`BTA_ASSERT_NEVER(a_no_issue_at_top, clk, arst_n, ram_we && max_q == TICKET_TOP, "ticket issued past the top value")
	`BTA_ASSERT(a_issue_sets_held, clk, arst_n, ram_we |=> held_q[$past(id_slot)], "held flag not set after issue")

endmodule

// ----- src/bta_ctrl.sv -----
// Controller: sequences accept, check, ticket walk and result load.
// Depends on bta_pkg and the assertion macro header.
`include "bakery_ticket_arbiter_core_defines.svh"

module bta_ctrl import bta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  bta_stat_t stat,
	output bta_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_WALK   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.latch    = 1'b0;
		cmd.check    = 1'b0;
		cmd.walk     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.latch = req_valid;
				if (req_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.none_active ? S_COMMIT : S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				// result register frees up when empty or taken this cycle
				cmd.load_out = !out_valid_q || rsp_ready;
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BTA_ASSERT(a_accept_to_check, clk, arst_n, (req_valid && req_ready) |=> state_q == S_CHECK, "accepted beat not followed by check")
	`BTA_ASSERT(a_drain_after_walk, clk, arst_n, state_q == S_DRAIN |-> $past(state_q) == S_WALK, "drain entered without a walk")
	`BTA_ASSERT(a_load_shows_result, clk, arst_n, cmd.load_out |=> rsp_valid, "loaded result not presented")

endmodule

// ----- src/bakery_ticket_arbiter_core.sv -----
// Bakery ticket arbiter. Each request or release beat yields one result beat
// giving the status, the issued ticket and the current holder (smallest
// nonzero ticket among active ids, ties to the lower id). The time per item is
// set by the active requester count n (saturated at 16): the datapath walks
// the ticket RAM one entry a cycle through its single registered read port to
// find the largest and smallest tickets. After the input beat is accepted the
// controller steps through a check state, a walk state over the active ids, a
// drain state for the read pipeline and a commit state that loads the result;
// commit waits while the output register holds an untaken result. The next
// input beat is taken only once the controller is back in idle. With no id
// active the walk and the drain are skipped.
// A finished result waits in an output register while the next beat is taken.
// A second result then waits in the commit state until the first is taken, and
// no further input beat is accepted meanwhile.
// The configuration register may be written at any time the block is idle.
module bakery_ticket_arbiter_core import bta_pkg::*; #(
	parameter int MAX_REQUESTERS = MAX_REQUESTERS_DEF,
	parameter int TICKET_BITS    = TICKET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_item_t        req_item,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_item_t        rsp_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ACT_W-1:0] cfg_data
);

	bta_cmd_t  cmd;
	bta_stat_t stat;

	assign cfg_ready = 1'b1;

	bta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bta_dp #(
		.MAX_REQ (MAX_REQUESTERS),
		.TB      (TICKET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req_item  (req_item),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_item  (rsp_item)
	);

endmodule
